// File: rtl/tcnw_pkg.sv
// ----------------------------------------------------------------------------
// Text console number writer package
// Shared types, screen geometry, request codes and character constants.
// ----------------------------------------------------------------------------
package tcnw_pkg;

  // Screen geometry and field widths.
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int ROW_W         = 5;
  localparam int COL_W         = 7;
  localparam int CELL_W        = 11;
  localparam int NUM_W         = 32;
  localparam int DIGITS        = 10;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int HEX_DIGITS    = NUM_W / 4;

  // Character codes.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] COLOR_RST  = 8'h0F;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_HEX  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_t;

  // Request payload.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [NUM_W-1:0] number;
  } in_t;

  // Cell write payload.
  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [7:0]        glyph;
    logic [7:0]        attribute;
    logic              last_of_run;
  } out_t;

  // Lowercase ASCII for one hex or decimal digit.
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] w;
    w = {4'b0000, d};
    return (d >= 4'd10) ? (w + 8'd87) : (w + CH_ZERO);
  endfunction

endpackage

// File: rtl/tcnw_dabble.sv
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module tcnw_dabble
  import tcnw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] value,
  output logic             done,
  output logic [BCD_W-1:0] bcd
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] bin;
  logic [BCD_W-1:0] adj;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? (bcd[4*i +: 4] + 4'd3) : bcd[4*i +: 4];
    end
  end

  // Control: busy flag, bit counter and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift registers: binary out at the top, BCD in at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[NUM_W-2:0], 1'b0};
      bcd <= {adj[BCD_W-2:0], bin[NUM_W-1]};
    end
  end

endmodule

// File: rtl/text_console_number_writer.sv
// ----------------------------------------------------------------------------
// Text console number writer
// Turns character, hex and decimal requests into cell writes at a cursor.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data (kind, char_code, number)
//   out       output     out_valid / out_ready out_data (cell, glyph, attr, last)
//   cfg       input      cfg_wr_en             cfg_wr_data (text color)
//
// One request is handled at a time; in_ready is high only while idle.
// A character makes one cell write; a newline makes none and only moves the cursor.
// Hex strips up to 7 leading zeros and makes 3..10 writes ("0x" and 1..8 digits).
// Decimal: 32 bit-serial BCD shifts, up to 9 leading zeros stripped, 1..10 writes.
// Each cell write waits on the output register, so out_ready stalls the run.
// Reset clears the cursor to row 0, column 0 and the color to 0x0F.
// ----------------------------------------------------------------------------
module text_console_number_writer
  import tcnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(DIGITS + 1);

  state_t             state;
  state_t             state_next;
  logic [7:0]         text_color;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [BCD_W-1:0]   digs;
  logic [CNT_W-1:0]   remaining;
  logic [1:0]         prefix;
  logic               is_char;
  logic [7:0]         char_reg;
  logic               conv_done;
  logic [BCD_W-1:0]   conv_bcd;

  logic               accept;
  logic               conv_start;
  logic               is_newline;
  logic               emit_fire;
  logic               strip_shift;
  logic               last;
  logic [7:0]         glyph;
  logic [CELL_W:0]    cell_full;

  // Decimal conversion unit.
  tcnw_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (in_data.number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_data.kind))
            KIND_CHAR: state_next = (in_data.char_code == CH_NEWLINE) ? ST_IDLE : ST_EMIT;
            KIND_HEX:  state_next = ST_STRIP;
            KIND_DEC:  state_next = ST_CONV;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_STRIP;
      end
      ST_STRIP: begin
        if (!strip_shift) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_fire && last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready    = (state == ST_IDLE);
    accept      = in_valid && in_ready;
    is_newline  = (in_data.char_code == CH_NEWLINE);
    conv_start  = accept && (kind_t'(in_data.kind) == KIND_DEC);
    emit_fire   = (state == ST_EMIT) && (!out_valid || out_ready);
    strip_shift = (state == ST_STRIP) && (digs[BCD_W-1 -: 4] == 4'd0) &&
                  (remaining > CNT_W'(1));
    last        = is_char || ((prefix == 2'd0) && (remaining == CNT_W'(1)));
    if (is_char) begin
      glyph = char_reg;
    end else if (prefix == 2'd2) begin
      glyph = CH_ZERO;
    end else if (prefix == 2'd1) begin
      glyph = CH_X;
    end else begin
      glyph = hex_char(digs[BCD_W-1 -: 4]);
    end
    cell_full = (CELL_W+1)'(row) * (CELL_W+1)'(SCREEN_WIDTH) + (CELL_W+1)'(col);
  end

  // State and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      text_color <= COLOR_RST;
    end else begin
      state <= state_next;
      if (cfg_wr_en) text_color <= cfg_wr_data;
    end
  end

  // Cursor: advances on each cell write, newline starts the next row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if ((accept && (kind_t'(in_data.kind) == KIND_CHAR) && is_newline) ||
                 (emit_fire && (col == COL_W'(SCREEN_WIDTH - 1)))) begin
      col <= '0;
      row <= (row == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : row + 1'b1;
    end else if (emit_fire) begin
      col <= col + 1'b1;
    end
  end

  // Digit buffer: loaded on a request, nibbles leave at the top.
  always_ff @(posedge clk) begin
    if (accept) begin
      char_reg  <= in_data.char_code;
      is_char   <= (kind_t'(in_data.kind) == KIND_CHAR);
      prefix    <= (kind_t'(in_data.kind) == KIND_HEX) ? 2'd2 : 2'd0;
      digs      <= {in_data.number, (BCD_W - NUM_W)'(0)};
      remaining <= CNT_W'(HEX_DIGITS);
    end else if (conv_done) begin
      digs      <= conv_bcd;
      remaining <= CNT_W'(DIGITS);
    end else if (strip_shift || (emit_fire && !is_char && (prefix == 2'd0))) begin
      digs      <= {digs[BCD_W-5:0], 4'd0};
      remaining <= remaining - 1'b1;
    end else if (emit_fire && !is_char) begin
      prefix    <= prefix - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.cell_index  <= cell_full[CELL_W-1:0];
      out_data.glyph       <= glyph;
      out_data.attribute   <= text_color;
      out_data.last_of_run <= last;
    end
  end

  // Checks on the cursor, the digit count and the converter.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (col < COL_W'(SCREEN_WIDTH)) && (row < ROW_W'(SCREEN_HEIGHT)))
    else $error("cursor outside the screen");

  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cell_index < CELL_W'(SCREEN_WIDTH * SCREEN_HEIGHT)))
    else $error("cell index outside the screen");

  a_digits_left: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && !is_char) |-> (remaining != '0))
    else $error("digit count ran out before the last write");

  a_conv_state: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == ST_CONV))
    else $error("conversion finished outside the conversion state");

endmodule

// File: tb/text_console_number_writer_test.sv
// ----------------------------------------------------------------------------
// Text console number writer regression
// Sends character, newline, hex and decimal requests through the valid/ready
// input and checks every cell write against an in-bench cursor model, with
// several text colors, random idling on both sides and a long output hold.
// ----------------------------------------------------------------------------
module text_console_number_writer_test
  import tcnw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_LEN      = 400;
  localparam int SHOWN_ERRORS  = 10;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  in_t        in_data     = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  out_t       out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  // Console model state.
  logic [ROW_W-1:0] cur_row    = '0;
  logic [COL_W-1:0] cur_col    = '0;
  logic [7:0]       text_color = COLOR_RST;

  // Cell writes predicted but not yet seen on the output.
  out_t pending_cells[$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  text_console_number_writer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Move the cursor to column 0 of the next row, wrapping at the screen end.
  function automatic void next_line();
    cur_col = '0;
    if (int'(cur_row) + 1 >= SCREEN_HEIGHT) begin
      cur_row = '0;
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endfunction

  // Expected cell writes for one accepted request; advances the cursor.
  function automatic void predict_cells(in_t req);
    logic [7:0]  glyphs[$];
    logic [31:0] v;
    logic [3:0]  d;
    bit          leading;
    out_t        c;
    int          idx;
    case (kind_t'(req.kind))
      KIND_CHAR: begin
        if (req.char_code == CH_NEWLINE) begin
          next_line();
        end else begin
          glyphs.push_back(req.char_code);
        end
      end
      KIND_HEX: begin
        glyphs.push_back(CH_ZERO);
        glyphs.push_back(CH_X);
        leading = 1'b1;
        for (int sh = 28; sh >= 0; sh -= 4) begin
          d = req.number[sh +: 4];
          if (d != 4'd0 || !leading || sh == 0) begin
            leading = 1'b0;
            glyphs.push_back((d < 4'd10) ? (CH_ZERO + 8'(d)) : (8'h61 + 8'(d) - 8'd10));
          end
        end
      end
      KIND_DEC: begin
        v = req.number;
        do begin
          glyphs.push_front(CH_ZERO + 8'(v % 32'd10));
          v = v / 32'd10;
        end while (v != 32'd0);
      end
      default: begin
      end
    endcase
    foreach (glyphs[i]) begin
      idx = int'(cur_row) * SCREEN_WIDTH + int'(cur_col);
      c.cell_index  = idx[CELL_W-1:0];
      c.glyph       = glyphs[i];
      c.attribute   = text_color;
      c.last_of_run = (i == glyphs.size() - 1);
      pending_cells.push_back(c);
      if (int'(cur_col) + 1 >= SCREEN_WIDTH) begin
        next_line();
      end else begin
        cur_col = cur_col + 1'b1;
      end
    end
  endfunction

  function automatic in_t make_request(kind_t k, logic [7:0] code, logic [31:0] num);
    in_t req;
    req.kind      = k;
    req.char_code = code;
    req.number    = num;
    return req;
  endfunction

  // Random request; numbers vary in length so every digit count shows up.
  function automatic in_t random_request(int newline_pct);
    in_t req;
    int  pick;
    req = make_request(KIND_NONE, 8'($urandom), $urandom);
    if ($urandom_range(99) < newline_pct) begin
      req.kind      = KIND_CHAR;
      req.char_code = CH_NEWLINE;
      return req;
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      req.kind = KIND_CHAR;
    end else if (pick < 65) begin
      req.kind = KIND_HEX;
    end else if (pick < 95) begin
      req.kind = KIND_DEC;
    end
    if ($urandom_range(1) == 1) begin
      req.number = $urandom >> $urandom_range(31);
    end
    return req;
  endfunction

  // Offer one request and wait for its transfer; valid stays high afterward.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_cells(req);
  endtask

  // Stop offering and wait until every expected cell write has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_text_color(logic [7:0] color);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    text_color = color;
    cfg_wr_en <= 1'b0;
  endtask

  // Field extremes, every kind, newline and the unused kind, at reset color.
  task automatic test_edge_requests();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_request(make_request(KIND_CHAR, 8'h00, 32'hFFFF_FFFF));
    send_request(make_request(KIND_CHAR, 8'hFF, 32'h0000_0000));
    send_request(make_request(KIND_CHAR, 8'h41, $urandom));
    send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
    send_request(make_request(KIND_CHAR, 8'h09, $urandom));
    send_request(make_request(KIND_HEX, 8'hFF, 32'h0000_0000));
    send_request(make_request(KIND_HEX, 8'h00, 32'hFFFF_FFFF));
    send_request(make_request(KIND_HEX, 8'($urandom), 32'h8000_0000));
    send_request(make_request(KIND_HEX, 8'($urandom), 32'h0000_000F));
    send_request(make_request(KIND_HEX, 8'($urandom), 32'h0000_0010));
    send_request(make_request(KIND_HEX, 8'($urandom), 32'hDEAD_BEEF));
    send_request(make_request(KIND_HEX, 8'($urandom), 32'h00AB_CDEF));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'd0));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'd9));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'd10));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'hFFFF_FFFF));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'h8000_0000));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'd1_000_000_000));
    send_request(make_request(KIND_DEC, 8'($urandom), 32'd999_999_999));
    send_request(make_request(KIND_NONE, 8'h41, 32'd12345));
    send_request(make_request(KIND_NONE, CH_NEWLINE, 32'hFFFF_FFFF));
    send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
    send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
  endtask

  // Color extremes and a mixed value, each used by a few requests.
  task automatic test_color_settings();
    logic [7:0] colors[3] = '{8'h00, 8'hFF, 8'hA5};
    foreach (colors[i]) begin
      set_text_color(colors[i]);
      send_request(make_request(KIND_CHAR, 8'h5A, $urandom));
      send_request(make_request(KIND_HEX, 8'($urandom), $urandom));
      send_request(make_request(KIND_DEC, 8'($urandom), $urandom));
    end
  endtask

  // Newline wrap from the last row, then column wrap at the last cell.
  task automatic test_screen_wrap();
    int guard;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (int'(cur_row) != SCREEN_HEIGHT - 1) begin
      send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
    end
    send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
    while (int'(cur_row) != SCREEN_HEIGHT - 1) begin
      send_request(make_request(KIND_CHAR, CH_NEWLINE, $urandom));
    end
    guard = 0;
    while (cur_row != '0 && guard < 20) begin
      send_request(make_request(KIND_DEC, 8'($urandom), 32'hFFFF_FFFF));
      guard++;
    end
  endtask

  // Random traffic in four idling phases, each with a new random color.
  task automatic test_random_traffic();
    int idle_mode[4]  = '{0, 86, 0, 30};
    int stall_mode[4] = '{0, 0, 86, 30};
    int newline_mode[4] = '{0, 25, 25, 25};
    for (int p = 0; p < 4; p++) begin
      set_text_color(8'($urandom));
      send_idle_pct = idle_mode[p];
      stall_pct     = stall_mode[p];
      repeat (20) send_request(random_request(newline_mode[p]));
    end
  endtask

  // Long receiver hold while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_asked++;
    repeat (3) begin
      send_request(make_request(KIND_DEC, 8'($urandom), 32'hFFFF_FFFF - $urandom_range(999)));
      send_request(make_request(KIND_HEX, 8'($urandom), $urandom | 32'hF000_0000));
    end
  endtask

  // Output ready: random stalls, plus a counted hold when one is requested.
  always @(posedge clk) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_LEN;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each cell write transfer with the oldest expectation.
  always @(posedge clk) begin : check_cells
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("unexpected cell write: cell %0d glyph %02h attr %02h last %0b",
                   out_data.cell_index, out_data.glyph, out_data.attribute,
                   out_data.last_of_run);
        end
      end else begin
        want = pending_cells.pop_front();
        if (out_data.cell_index !== want.cell_index || out_data.glyph !== want.glyph ||
            out_data.attribute !== want.attribute ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("cell write mismatch: expected cell %0d glyph %02h attr %02h last %0b,",
                     want.cell_index, want.glyph, want.attribute, want.last_of_run);
            $display("  got cell %0d glyph %02h attr %02h last %0b",
                     out_data.cell_index, out_data.glyph, out_data.attribute,
                     out_data.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_edge_requests();
    test_color_settings();
    test_screen_wrap();
    test_random_traffic();
    test_output_backpressure();
    settle();
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("text_console_number_writer regression: pass");
    end else begin
      $display("text_console_number_writer regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("text_console_number_writer regression: fail");
    $finish;
  end

endmodule
